// ===== hw/rtl/odb_pkg.sv =====
// Shared types, constants and helpers for the operating point efficiency binner.
// No dependencies; imported by odb_div and the top level module.
package odb_pkg;

    localparam int BINS   = 24;
    localparam int BIN_W  = $clog2(BINS);
    localparam int CELLS  = BINS * BINS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SUM_W  = 40;
    localparam int CNT_W  = 16;
    localparam int CELL_W = SUM_W + CNT_W;
    localparam int DIV_W  = 40;
    localparam int DVS_W  = 16;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    localparam logic [2:0] MODE_LOAD_TEMP = 3'd0;
    localparam logic [2:0] MODE_LOAD_FLOW = 3'd1;
    localparam logic [2:0] MODE_RECORD    = 3'd2;
    localparam logic [2:0] MODE_READ      = 3'd3;
    localparam logic [2:0] MODE_CLEAR     = 3'd4;

    localparam logic [2:0] CFG_REF_TEMP  = 3'd0;
    localparam logic [2:0] CFG_TEMP_LOW  = 3'd1;
    localparam logic [2:0] CFG_TEMP_HIGH = 3'd2;
    localparam logic [2:0] CFG_FLOW_LOW  = 3'd3;
    localparam logic [2:0] CFG_FLOW_HIGH = 3'd4;

    localparam logic [15:0] RST_TEMP_LOW  = 16'd200;
    localparam logic [15:0] RST_TEMP_HIGH = 16'd625;
    localparam logic [15:0] RST_FLOW_LOW  = 16'd250;
    localparam logic [15:0] RST_FLOW_HIGH = 16'd1000;

    localparam logic [15:0] CONV_FULL  = 16'd10000;
    localparam logic [2:0]  CLASS_EMPTY = 3'd7;
    localparam logic [CNT_W-1:0] CNT_FULL = {CNT_W{1'b1}};

    // Saturate a sign and magnitude quotient to signed 16 bits.
    function automatic logic [15:0] sat16(input logic [DIV_W-1:0] q, input logic neg);
        logic [DIV_W-1:0] nq;
        nq = DIV_W'(0) - q;
        if (!neg)
            return (q > DIV_W'(32767)) ? 16'h7fff : q[15:0];
        else
            return (q > DIV_W'(32768)) ? 16'h8000 : nq[15:0];
    endfunction

    // Efficiency class of a nonempty cell mean in hundredths of a percent.
    function automatic logic [2:0] eff_class(input logic [15:0] a);
        logic signed [15:0] s;
        s = $signed(a);
        if (s < 16'sd3000)      return 3'd0;
        else if (s < 16'sd4000) return 3'd1;
        else if (s < 16'sd5000) return 3'd2;
        else if (s < 16'sd6000) return 3'd3;
        else if (s < 16'sd7000) return 3'd4;
        else if (s < 16'sd8000) return 3'd5;
        else                    return 3'd6;
    endfunction

endpackage

// ===== hw/rtl/odb_ram.sv =====
// Generic single port write, single port read RAM with registered read data.
// No dependencies.
module odb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/odb_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on odb_pkg for operand widths.
module odb_div import odb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);
    logic [DVS_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [DVS_W-1:0]  r_dvs;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy, r_done;
    logic [DVS_W:0]    trial;

    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = DVS_W'(trial - {1'b0, r_dvs});
            n_quo = {r_quo[DIV_W-2:0], 1'b1};
        end else begin
            n_rem = trial[DVS_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ===== hw/rtl/operating_point_efficiency_binner.sv =====
// Top level of the operating point efficiency binner.
// Depends on odb_pkg, odb_ram (cell grid) and odb_div (shared divider).
//
// Usage:
//  - Requests enter on i_in_valid / o_in_ready; one result leaves per request on
//    o_out_valid / i_out_ready. Modes: load temperature or flow breakpoint,
//    record, read cell, clear.
//  - The user writes configuration registers via i_cfg_we / i_cfg_idx / i_cfg_data
//    only while the block is idle; the block itself does not enforce this.
//  - The block works on one request at a time and is not ready meanwhile.
//    A record takes one multiply, a divide in the bit-serial divider unless
//    the upstream NOx is zero, a window check and, inside the window, a
//    BINS-step breakpoint scan and a read-modify-write of the grid RAM.
//    A readout of a nonempty cell uses the same divider.
//    A clear sweeps all BINS*BINS (576) grid cells, one per cycle.
//  - After reset the block clears the grid RAM before it accepts the first
//    request; breakpoints, totals and registers reset at once.
//  - A finished result sits in the output register; while the receiver
//    stalls, the next request may be accepted and worked, and its result
//    waits until the output register frees.
module operating_point_efficiency_binner import odb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_mode,
    input  logic [4:0]  i_index,
    input  logic [15:0] i_breakpoint_value,
    input  logic [4:0]  i_column,
    input  logic signed [15:0] i_nox_upstream,
    input  logic signed [15:0] i_nox_downstream,
    input  logic [15:0] i_air_flow,
    input  logic [15:0] i_avg_temperature,
    input  logic [15:0] i_dosing,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_row_bin,
    output logic [4:0]  o_col_bin,
    output logic        o_in_window,
    output logic signed [15:0] o_conversion,
    output logic signed [15:0] o_cell_average,
    output logic [15:0] o_cell_count,
    output logic [2:0]  o_efficiency_class,
    output logic [31:0] o_nox_up_total,
    output logic [31:0] o_nox_down_total,
    output logic [31:0] o_dosed_up_total,
    output logic [31:0] o_dosed_down_total,
    output logic [31:0] o_dosing_total
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_WIN  = 4'd4;
    localparam logic [3:0] S_SRCH = 4'd5;
    localparam logic [3:0] S_GRD  = 4'd6;
    localparam logic [3:0] S_GWR  = 4'd7;
    localparam logic [3:0] S_RDD  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0] r_state;

    // configuration registers
    logic [15:0] r_ref_temp, r_t_low, r_t_high, r_f_low, r_f_high;

    // breakpoints
    logic [15:0] r_t_bp [BINS];
    logic [15:0] r_f_bp [BINS];

    // latched request
    logic [2:0]         r_mode;
    logic signed [15:0] r_up, r_down;
    logic [15:0]        r_flow, r_temp;

    // persistent state
    logic [BIN_W-1:0] r_last_row, r_last_col;
    logic [31:0] r_up_sum, r_down_sum, r_dup_sum, r_ddown_sum, r_dose_sum;

    // working registers
    logic [ADDR_W-1:0] r_clr_cnt, r_addr;
    logic              r_clr_emit;
    logic [BIN_W-1:0]  r_k, r_t_bin, r_f_bin;
    logic              r_t_found, r_f_found;
    logic [15:0]       r_t_prev, r_f_prev;
    logic              r_neg;

    // result registers
    logic [4:0]  r_res_row, r_res_col;
    logic        r_res_inw;
    logic [15:0] r_res_conv, r_res_avg, r_res_cnt;
    logic [2:0]  r_res_cls;

    // output register
    logic        r_out_valid;
    logic [4:0]  r_o_row, r_o_col;
    logic        r_o_inw;
    logic [15:0] r_o_conv, r_o_avg, r_o_cnt;
    logic [2:0]  r_o_cls;
    logic [31:0] r_o_up, r_o_down, r_o_dup, r_o_ddown, r_o_dose;

    // divider and RAM hookup
    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_dividend, div_quo;
    logic [DVS_W-1:0]  div_divisor;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    logic              in_acc;
    logic signed [16:0] diff;
    logic signed [30:0] prod;
    logic [30:0]       prod_abs;
    logic [16:0]       up_abs;
    logic [15:0]       t_bp_k, f_bp_k, quo_sat;
    logic [BIN_W-1:0]  t_fin, f_fin;
    logic [SUM_W-1:0]  cell_sum, sum_abs;
    logic [CNT_W-1:0]  cell_cnt;
    logic              t_hit, f_hit;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    assign diff     = 17'(r_up) - 17'(r_down);
    assign prod     = 31'(diff) * 31'sd10000;
    assign prod_abs = prod[30] ? 31'(-prod) : 31'(prod);
    assign up_abs   = r_up[15] ? 17'(-17'(r_up)) : 17'(r_up);

    assign t_bp_k = r_t_bp[r_k];
    assign f_bp_k = r_f_bp[r_k];

    // first interval match; the first step tests "at or below the first breakpoint"
    assign t_hit = (r_k == '0) ? (r_temp <= t_bp_k) : (r_temp > r_t_prev && r_temp <= t_bp_k);
    assign f_hit = (r_k == '0) ? (r_flow <= f_bp_k) : (r_flow > r_f_prev && r_flow <= f_bp_k);

    // final bins at the last step: above the last breakpoint wins, then a match, then keep
    always_comb begin
        if (r_temp > t_bp_k)      t_fin = BIN_W'(BINS - 1);
        else if (r_t_found)       t_fin = r_t_bin;
        else if (t_hit)           t_fin = BIN_W'(BINS - 2);
        else                      t_fin = r_last_row;
        if (r_flow > f_bp_k)      f_fin = BIN_W'(BINS - 1);
        else if (r_f_found)       f_fin = r_f_bin;
        else if (f_hit)           f_fin = BIN_W'(BINS - 2);
        else                      f_fin = r_last_col;
    end

    assign cell_sum = ram_rdata[CELL_W-1:CNT_W];
    assign cell_cnt = ram_rdata[CNT_W-1:0];
    assign sum_abs  = cell_sum[SUM_W-1] ? SUM_W'(-cell_sum) : cell_sum;
    assign quo_sat  = sat16(div_quo, r_neg);

    // divider feed
    always_comb begin
        div_start    = 1'b0;
        div_dividend = DIV_W'(prod_abs);
        div_divisor  = up_abs[DVS_W-1:0];
        if (r_state == S_MUL && r_up != 16'sd0) begin
            div_start = 1'b1;
        end else if (r_state == S_RDD && cell_cnt != '0) begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(sum_abs);
            div_divisor  = DVS_W'(cell_cnt);
        end
    end

    // grid RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = {SUM_W'(cell_sum + SUM_W'($signed(r_res_conv))), CNT_W'(cell_cnt + 1'b1)};
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_cnt;
            ram_wdata = '0;
        end else if (r_state == S_GWR && cell_cnt != CNT_FULL) begin
            ram_we = 1'b1;
        end
    end
    assign ram_re = (r_state == S_GRD);

    odb_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    odb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_temp <= '0;
            r_t_low    <= RST_TEMP_LOW;
            r_t_high   <= RST_TEMP_HIGH;
            r_f_low    <= RST_FLOW_LOW;
            r_f_high   <= RST_FLOW_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REF_TEMP:  r_ref_temp <= i_cfg_data;
                CFG_TEMP_LOW:  r_t_low    <= i_cfg_data;
                CFG_TEMP_HIGH: r_t_high   <= i_cfg_data;
                CFG_FLOW_LOW:  r_f_low    <= i_cfg_data;
                CFG_FLOW_HIGH: r_f_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // breakpoint tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BINS; i++) begin
                r_t_bp[i] <= '0;
                r_f_bp[i] <= '0;
            end
        end else if (in_acc && 32'(i_index) < BINS) begin
            if (i_mode == MODE_LOAD_TEMP) r_t_bp[BIN_W'(i_index)] <= i_breakpoint_value;
            if (i_mode == MODE_LOAD_FLOW) r_f_bp[BIN_W'(i_index)] <= i_breakpoint_value;
        end
    end

    // latch request fields
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_mode;
            r_up   <= i_nox_upstream;
            r_down <= i_nox_downstream;
            r_flow <= i_air_flow;
            r_temp <= i_avg_temperature;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_cnt   <= '0;
            r_clr_emit  <= 1'b0;
            r_last_row  <= '0;
            r_last_col  <= '0;
            r_up_sum    <= '0;
            r_down_sum  <= '0;
            r_dup_sum   <= '0;
            r_ddown_sum <= '0;
            r_dose_sum  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop valid once the result is taken; S_FIN refills the register itself
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_res_row  <= '0;
                        r_res_col  <= '0;
                        r_res_inw  <= 1'b0;
                        r_res_conv <= '0;
                        r_res_avg  <= '0;
                        r_res_cnt  <= '0;
                        r_res_cls  <= (i_mode == MODE_READ) ? CLASS_EMPTY : '0;
                        case (i_mode)
                            MODE_RECORD: begin
                                // totals update at once; only NOx sums gated by ref temp
                                if (i_avg_temperature >= r_ref_temp) begin
                                    r_up_sum   <= r_up_sum + 32'($signed(i_nox_upstream));
                                    r_down_sum <= r_down_sum + 32'($signed(i_nox_downstream));
                                    if (i_dosing != '0) begin
                                        r_dup_sum   <= r_dup_sum + 32'($signed(i_nox_upstream));
                                        r_ddown_sum <= r_ddown_sum +
                                                       32'($signed(i_nox_downstream));
                                    end
                                end
                                r_dose_sum <= r_dose_sum + 32'(i_dosing);
                                r_state    <= S_MUL;
                            end
                            MODE_READ: begin
                                if (32'(i_index) < BINS && 32'(i_column) < BINS) begin
                                    r_addr  <= ADDR_W'(32'(i_index) * BINS + 32'(i_column));
                                    r_state <= S_GRD;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            MODE_CLEAR: begin
                                r_last_row  <= '0;
                                r_last_col  <= '0;
                                r_up_sum    <= '0;
                                r_down_sum  <= '0;
                                r_dup_sum   <= '0;
                                r_ddown_sum <= '0;
                                r_dose_sum  <= '0;
                                r_clr_cnt   <= '0;
                                r_clr_emit  <= 1'b1;
                                r_state     <= S_CLR;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_CLR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == ADDR_W'(CELLS - 1)) begin
                        r_state <= r_clr_emit ? S_FIN : S_IDLE;
                    end
                end
                S_MUL: begin
                    r_neg <= prod[30] ^ r_up[15];
                    if (r_up == 16'sd0) begin
                        r_res_conv <= CONV_FULL;
                        r_state    <= S_WIN;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_mode == MODE_RECORD) begin
                            r_res_conv <= quo_sat;
                            r_state    <= S_WIN;
                        end else begin
                            r_res_avg <= quo_sat;
                            r_res_cls <= eff_class(quo_sat);
                            r_state   <= S_FIN;
                        end
                    end
                end
                S_WIN: begin
                    if (r_temp >= r_t_low && r_temp < r_t_high &&
                        r_flow >= r_f_low && r_flow < r_f_high) begin
                        r_k       <= '0;
                        r_t_found <= 1'b0;
                        r_f_found <= 1'b0;
                        r_state   <= S_SRCH;
                    end else begin
                        r_last_row <= '0;
                        r_last_col <= '0;
                        r_state    <= S_FIN;
                    end
                end
                S_SRCH: begin
                    // advance one breakpoint per cycle, holding the previous one
                    r_t_prev <= t_bp_k;
                    r_f_prev <= f_bp_k;
                    if (!r_t_found && t_hit) begin
                        r_t_found <= 1'b1;
                        r_t_bin   <= (r_k == '0) ? '0 : BIN_W'(r_k - 1'b1);
                    end
                    if (!r_f_found && f_hit) begin
                        r_f_found <= 1'b1;
                        r_f_bin   <= (r_k == '0) ? '0 : BIN_W'(r_k - 1'b1);
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == BIN_W'(BINS - 1)) begin
                        r_last_row <= t_fin;
                        r_last_col <= f_fin;
                        r_res_row  <= 5'(t_fin);
                        r_res_col  <= 5'(f_fin);
                        r_res_inw  <= 1'b1;
                        r_addr     <= ADDR_W'(32'(t_fin) * BINS + 32'(f_fin));
                        r_state    <= S_GRD;
                    end
                end
                S_GRD: begin
                    r_state <= (r_mode == MODE_RECORD) ? S_GWR : S_RDD;
                end
                S_GWR: begin
                    r_state <= S_FIN;
                end
                S_RDD: begin
                    r_res_cnt <= cell_cnt;
                    r_neg     <= cell_sum[SUM_W-1];
                    r_state   <= (cell_cnt == '0) ? S_FIN : S_DIV;
                end
                S_FIN: begin
                    // wait for a free output register
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_row     <= r_res_row;
                        r_o_col     <= r_res_col;
                        r_o_inw     <= r_res_inw;
                        r_o_conv    <= r_res_conv;
                        r_o_avg     <= r_res_avg;
                        r_o_cnt     <= r_res_cnt;
                        r_o_cls     <= r_res_cls;
                        r_o_up      <= r_up_sum;
                        r_o_down    <= r_down_sum;
                        r_o_dup     <= r_dup_sum;
                        r_o_ddown   <= r_ddown_sum;
                        r_o_dose    <= r_dose_sum;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_row_bin          = r_o_row;
    assign o_col_bin          = r_o_col;
    assign o_in_window        = r_o_inw;
    assign o_conversion       = $signed(r_o_conv);
    assign o_cell_average     = $signed(r_o_avg);
    assign o_cell_count       = r_o_cnt;
    assign o_efficiency_class = r_o_cls;
    assign o_nox_up_total     = r_o_up;
    assign o_nox_down_total   = r_o_down;
    assign o_dosed_up_total   = r_o_dup;
    assign o_dosed_down_total = r_o_ddown;
    assign o_dosing_total     = r_o_dose;
endmodule
